// ===== hdl/qcsr_pkg.sv =====
// Shared types and constants for the QUIC connection-ID socket router.
package qcsr_pkg;

  // Configuration port
  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned CFG_INDEX_W = 2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_REGISTERED_MASK  = 2'd0,
    CFG_EXPECTED_CID_LEN = 2'd1,
    CFG_MIN_LONG_LEN     = 2'd2,
    CFG_MIN_SHORT_LEN    = 2'd3
  } cfg_index_t;

  // Register reset values
  localparam logic [7:0] RST_EXPECTED_CID_LEN = 8'd8;
  localparam logic [7:0] RST_MIN_LONG_LEN     = 8'd14;
  localparam logic [7:0] RST_MIN_SHORT_LEN    = 8'd9;

  // Key table size
  localparam int unsigned DEFAULT_MAX_KEYS = 64;

  // Route decision codes
  typedef enum logic [1:0] {
    ROUTE_BY_SID      = 2'd0,
    ROUTE_DEFAULT_KEY = 2'd1,
    ROUTE_KERNEL_HASH = 2'd2
  } route_kind_t;

  // Packet layout
  localparam logic [15:0] UDP_HDR_LEN     = 16'd8;
  localparam logic [15:0] MIN_SKIP_BYTES  = 16'd6;   // bytes needed to see the UDP length
  localparam logic [15:0] LONG_DCID_OFS   = 16'd5;
  localparam logic [15:0] LONG_CID_OFS    = 16'd6;
  localparam logic [15:0] SHORT_CID_OFS   = 16'd1;
  localparam logic [15:0] SID_BYTES       = 16'd4;
  localparam logic [15:0] UDP_LEN_HI_POS  = 16'd4;
  localparam logic [15:0] UDP_LEN_LO_POS  = 16'd5;
  localparam int unsigned LONG_FLAG_BIT   = 7;

endpackage

// ===== hdl/quic_cid_socket_router.sv =====
// QUIC connection-ID socket router: byte-stream header decode and route select.
//
// Takes a packet one byte per request on the in_ channel (packet_length is
// sampled with the start-of-packet mark) and, on the request carrying
// last_byte, returns one route on the out_ channel. A leading 8-byte UDP
// header is recognized when the packet has at least 6 bytes and bytes 4-5
// (big-endian) equal the reported length. The first payload byte's bit 7 picks
// long or short header form; the first four connection-ID bytes form a
// big-endian server id. Route order: server id if that key is set in
// registered_mask, else key 0 if set, else kernel hashing. A failed parse
// reports a zero server id and id_extracted 0.
// Rate: one byte per clock while no last byte waits on the result register.
// The input register takes the byte, and the decode is then loaded into the
// result register. Only a last byte waits, and only while the previous result
// is still held by out_stall; other bytes keep flowing. The registers hold no
// copy of the packet, just the bytes at fixed offsets that the decode can use.
// Configuration writes are taken at any time but must only be issued while
// the block is idle.
module quic_cid_socket_router
  import qcsr_pkg::*;
#(
  parameter int unsigned MAX_KEYS = DEFAULT_MAX_KEYS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // byte requests
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             in_data_byte,
  input  logic                   in_start_byte,
  input  logic                   in_last_byte,
  input  logic [15:0]            in_packet_length,
  // route results
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [1:0]             out_route_kind,
  output logic [31:0]            out_srv_id,
  output logic                   out_id_extracted,
  output logic                   out_header_skipped,
  // configuration writes
  input  logic                   cfg_write_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int unsigned KEY_W = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;

  // Window start offsets, without and with a skipped UDP header
  localparam logic [15:0] WIN_SHORT     = SHORT_CID_OFS;
  localparam logic [15:0] WIN_LONG      = LONG_CID_OFS;
  localparam logic [15:0] WIN_SHORT_UDP = UDP_HDR_LEN + SHORT_CID_OFS;
  localparam logic [15:0] WIN_LONG_UDP  = UDP_HDR_LEN + LONG_CID_OFS;
  localparam logic [15:0] DCID_UDP_POS  = UDP_HDR_LEN + LONG_DCID_OFS;

  // ---------------------------------------------------------------- config
  logic [MAX_KEYS-1:0] key_mask_r;
  logic [7:0]          exp_cid_len_r;
  logic [7:0]          min_long_r;
  logic [7:0]          min_short_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_mask_r    <= '0;
      exp_cid_len_r <= RST_EXPECTED_CID_LEN;
      min_long_r    <= RST_MIN_LONG_LEN;
      min_short_r   <= RST_MIN_SHORT_LEN;
    end else if (cfg_write_en) begin
      case (cfg_index_t'(cfg_index))
        CFG_REGISTERED_MASK:  key_mask_r    <= cfg_wdata[MAX_KEYS-1:0];
        CFG_EXPECTED_CID_LEN: exp_cid_len_r <= cfg_wdata[7:0];
        CFG_MIN_LONG_LEN:     min_long_r    <= cfg_wdata[7:0];
        CFG_MIN_SHORT_LEN:    min_short_r   <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------- input stage
  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;
  logic        s1_first_r;
  logic        s1_last_r;
  logic [15:0] s1_len_r;

  logic out_valid_r;
  logic out_free;
  logic s1_go;
  logic s1_fire;
  logic in_accept;

  // A last byte needs the result register; anything else just updates state.
  assign out_free  = !out_valid_r || !out_stall;
  assign s1_go     = !s1_last_r || out_free;
  assign s1_fire   = s1_valid_r && s1_go;
  assign in_stall  = s1_valid_r && !s1_go;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_byte_r  <= in_data_byte;
      s1_first_r <= in_start_byte;
      s1_last_r  <= in_last_byte;
      s1_len_r   <= in_packet_length;
    end
  end

  // --------------------------------------------------------- packet state
  logic [15:0] cnt_r, cnt_nxt;           // bytes seen, saturating
  logic [15:0] len_hold_r, len_hold_nxt;
  logic [15:0] udp_len_r, udp_len_nxt;
  logic [7:0]  b0_r, b0_nxt;             // flags, no UDP header
  logic [7:0]  b8_r, b8_nxt;             // flags after UDP header
  logic [7:0]  b13_r, b13_nxt;           // DCID length after UDP header
  logic [31:0] win_s_r, win_s_nxt;       // short CID bytes 1..4
  logic [31:0] win_l_r, win_l_nxt;       // long CID bytes 6..9
  logic [31:0] win_su_r, win_su_nxt;     // short CID bytes 9..12
  logic [31:0] win_lu_r, win_lu_nxt;     // long CID bytes 14..17

  logic [15:0] pos;      // offset of the current byte
  logic [15:0] total;    // byte count including the current byte
  logic [15:0] udp_base; // UDP length before this byte lands
  logic [15:0] udp_cur;  // UDP length once this byte has landed

  function automatic logic in_win(input logic [15:0] p, input logic [15:0] start);
    in_win = (p >= start) && (p < start + SID_BYTES);
  endfunction

  always_comb begin
    pos          = s1_first_r ? 16'd0 : cnt_r;
    total        = (pos == 16'hFFFF) ? pos : pos + 16'd1;
    len_hold_nxt = s1_first_r ? s1_len_r : len_hold_r;
    udp_base     = s1_first_r ? 16'd0 : udp_len_r;

    udp_cur = udp_base;
    if (pos == UDP_LEN_HI_POS) begin
      udp_cur = {s1_byte_r, udp_base[7:0]};
    end else if (pos == UDP_LEN_LO_POS) begin
      udp_cur = {udp_base[15:8], s1_byte_r};
    end

    b0_nxt  = (pos == 16'd0)        ? s1_byte_r : b0_r;
    b8_nxt  = (pos == UDP_HDR_LEN)  ? s1_byte_r : b8_r;
    b13_nxt = (pos == DCID_UDP_POS) ? s1_byte_r : b13_r;

    win_s_nxt  = in_win(pos, WIN_SHORT)     ? {win_s_r[23:0], s1_byte_r}  : win_s_r;
    win_l_nxt  = in_win(pos, WIN_LONG)      ? {win_l_r[23:0], s1_byte_r}  : win_l_r;
    win_su_nxt = in_win(pos, WIN_SHORT_UDP) ? {win_su_r[23:0], s1_byte_r} : win_su_r;
    win_lu_nxt = in_win(pos, WIN_LONG_UDP)  ? {win_lu_r[23:0], s1_byte_r} : win_lu_r;

    // the packet closes on its last byte
    cnt_nxt     = s1_last_r ? 16'd0 : total;
    udp_len_nxt = s1_last_r ? 16'd0 : udp_cur;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      len_hold_r <= '0;
      udp_len_r  <= '0;
    end else if (s1_fire) begin
      cnt_r      <= cnt_nxt;
      len_hold_r <= len_hold_nxt;
      udp_len_r  <= udp_len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      b0_r     <= b0_nxt;
      b8_r     <= b8_nxt;
      b13_r    <= b13_nxt;
      win_s_r  <= win_s_nxt;
      win_l_r  <= win_l_nxt;
      win_su_r <= win_su_nxt;
      win_lu_r <= win_lu_nxt;
    end
  end

  // --------------------------------------------------------------- decode
  // Uses the _nxt views so that the last byte itself is part of the decode.
  logic        skip;
  logic [15:0] base;
  logic [15:0] n_payload;
  logic [7:0]  flags;
  logic        long_hdr;
  logic [7:0]  cid_len_byte;
  logic        parse_ok;
  logic [31:0] sid;
  logic        sid_reg;
  logic        key0_reg;
  route_kind_t kind;

  always_comb begin
    // bytes 4-5 are only compared once both have arrived in this packet
    skip         = (total >= MIN_SKIP_BYTES) && (udp_cur == len_hold_nxt);
    base         = skip ? UDP_HDR_LEN : 16'd0;
    n_payload    = total - base;
    flags        = skip ? b8_nxt : b0_nxt;
    long_hdr     = flags[LONG_FLAG_BIT];
    cid_len_byte = skip ? b13_nxt : udp_cur[7:0];

    if (total < base + 16'd1) begin
      parse_ok = 1'b0;
    end else if (long_hdr) begin
      parse_ok = (n_payload >= {8'd0, min_long_r})
              && (total >= base + LONG_CID_OFS)
              && (cid_len_byte == exp_cid_len_r)
              && (total >= base + LONG_CID_OFS + SID_BYTES);
    end else begin
      parse_ok = (n_payload >= {8'd0, min_short_r})
              && (total >= base + SHORT_CID_OFS + SID_BYTES);
    end

    case ({skip, long_hdr})
      2'b00:   sid = win_s_nxt;
      2'b01:   sid = win_l_nxt;
      2'b10:   sid = win_su_nxt;
      2'b11:   sid = win_lu_nxt;
      default: sid = win_s_nxt;
    endcase

    // keys at or beyond MAX_KEYS are never registered
    sid_reg  = (sid < 32'(MAX_KEYS)) && key_mask_r[sid[KEY_W-1:0]];
    key0_reg = key_mask_r[0];

    if (parse_ok && sid_reg) begin
      kind = ROUTE_BY_SID;
    end else if (key0_reg) begin
      kind = ROUTE_DEFAULT_KEY;
    end else begin
      kind = ROUTE_KERNEL_HASH;
    end
  end

  // --------------------------------------------------------- result stage
  logic [1:0]  route_kind_r;
  logic [31:0] srv_id_r;
  logic        id_extracted_r;
  logic        hdr_skipped_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_last_r) begin
      route_kind_r   <= kind;
      srv_id_r       <= parse_ok ? sid : 32'd0;
      id_extracted_r <= parse_ok;
      hdr_skipped_r  <= skip;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_route_kind     = route_kind_r;
  assign out_srv_id         = srv_id_r;
  assign out_id_extracted   = id_extracted_r;
  assign out_header_skipped = hdr_skipped_r;

`ifndef SYNTHESIS
  // only a last byte facing a held result may back-pressure the input
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && s1_last_r && out_valid_r && out_stall))
    else $error("input stalled without a blocked last byte");

  // a server-id route requires a parsed id
  a_route_needs_id: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_route_kind == ROUTE_BY_SID)) |-> out_id_extracted)
    else $error("server-id route without extracted id");

  // a failed parse reports a zero server id
  a_fail_zero_id: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_id_extracted) |-> (out_srv_id == 32'd0))
    else $error("nonzero server id on failed parse");

  // closing a packet clears the byte counter
  a_close_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_last_r) |=> ((cnt_r == 16'd0) && (udp_len_r == 16'd0)))
    else $error("packet state not cleared after last byte");
`endif

endmodule

// ===== tb/sv/tb_quic_cid_socket_router.sv =====
// Self-checking testbench for the QUIC connection-ID socket router.
`timescale 1ns / 1ps

module tb_quic_cid_socket_router;
  import qcsr_pkg::*;

  localparam int unsigned MAX_KEYS      = DEFAULT_MAX_KEYS;
  localparam int unsigned CAP_BYTES     = 18;      // no byte past offset 17 matters
  localparam int          SETTLE_CYCLES = 6;       // drain of the input and result registers plus margin
  localparam int          CYCLE_LIMIT   = 1000000;
  localparam int          PRINT_CAP     = 100;

  typedef logic [7:0] octet_t;

  // One byte request on the in_ channel
  typedef struct {
    logic [7:0]  data;
    logic        first;
    logic        last;
    logic [15:0] plen;
  } byte_req_t;

  // One expected route on the out_ channel
  typedef struct {
    route_kind_t kind;
    logic [31:0] sid;
    logic        extracted;
    logic        skipped;
  } route_expect_t;

  // ---------------------------------------------------------------------------
  // Clock, reset, DUT pins (every input known from time zero)
  // ---------------------------------------------------------------------------
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic        in_valid         = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte     = '0;
  logic        in_start_byte    = 1'b0;
  logic        in_last_byte     = 1'b0;
  logic [15:0] in_packet_length = '0;

  logic        out_valid;
  logic        out_stall        = 1'b0;
  logic [1:0]  out_route_kind;
  logic [31:0] out_srv_id;
  logic        out_id_extracted;
  logic        out_header_skipped;

  logic                  cfg_write_en = 1'b0;
  cfg_index_t            cfg_index    = CFG_REGISTERED_MASK;
  logic [CFG_DATA_W-1:0] cfg_wdata    = '0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  quic_cid_socket_router u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_start_byte     (in_start_byte),
    .in_last_byte      (in_last_byte),
    .in_packet_length  (in_packet_length),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_route_kind    (out_route_kind),
    .out_srv_id        (out_srv_id),
    .out_id_extracted  (out_id_extracted),
    .out_header_skipped(out_header_skipped),
    .cfg_write_en      (cfg_write_en),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // Shadow copy of the registers and of the byte-stream decode state
  // ---------------------------------------------------------------------------
  logic [63:0] reg_mask      = '0;
  logic [7:0]  reg_exp_cid   = RST_EXPECTED_CID_LEN;
  logic [7:0]  reg_min_long  = RST_MIN_LONG_LEN;
  logic [7:0]  reg_min_short = RST_MIN_SHORT_LEN;

  logic [15:0] pk_count   = '0;   // bytes seen in the open packet, saturating
  logic [15:0] pk_len_hold = '0;  // packet_length taken with the first byte
  logic [15:0] pk_udp_len = '0;   // raw bytes 4-5
  logic [7:0]  pk_cap [0:CAP_BYTES-1];

  byte_req_t     byte_q[$];          // requests waiting for the driver
  route_expect_t route_expect_q[$];  // routes the DUT still owes us
  octet_t        pkt_bytes[$];       // packet under construction

  int mismatch_count = 0;
  int phase_items    = 0;
  int cycle_count    = 0;

  initial begin
    for (int i = 0; i < CAP_BYTES; i++) pk_cap[i] = '0;
  end

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  function automatic bit key_set(input logic [31:0] key);
    if (key >= MAX_KEYS) return 1'b0;
    return reg_mask[key[5:0]];
  endfunction

  // Advance the decode by one accepted byte; on a last byte queue the route.
  task automatic predict_route(input byte_req_t req);
    int unsigned   total, base, n, cid;
    bit            ok;
    logic [31:0]   sid;
    logic [7:0]    flags;
    route_expect_t e;
    if (req.first) begin
      pk_count    = '0;
      pk_udp_len  = '0;
      pk_len_hold = req.plen;
    end
    if (pk_count < CAP_BYTES) pk_cap[pk_count] = req.data;
    if (pk_count == 16'd4)      pk_udp_len[15:8] = req.data;
    else if (pk_count == 16'd5) pk_udp_len[7:0]  = req.data;
    if (pk_count != 16'hFFFF) pk_count++;
    if (req.last) begin
      total     = pk_count;
      ok        = 1'b0;
      sid       = '0;
      cid       = 0;
      // UDP header shows up as bytes 4-5 matching the reported length
      e.skipped = (total >= 6) && (pk_udp_len == pk_len_hold);
      base      = e.skipped ? 8 : 0;
      if (total >= base + 1) begin
        n     = total - base;
        flags = pk_cap[base];
        if (flags[LONG_FLAG_BIT]) begin
          // long form: DCID length byte must be present and match
          if (n >= reg_min_long && total >= base + 6 && pk_cap[base + 5] == reg_exp_cid) begin
            cid = base + 6;
            ok  = 1'b1;
          end
        end else if (n >= reg_min_short) begin
          cid = base + 1;
          ok  = 1'b1;
        end
        // CID bytes past the end of the packet fail the parse
        if (ok && total < cid + 4) ok = 1'b0;
        if (ok) sid = {pk_cap[cid], pk_cap[cid + 1], pk_cap[cid + 2], pk_cap[cid + 3]};
      end
      e.sid       = sid;
      e.extracted = ok;
      if (ok && key_set(sid)) e.kind = ROUTE_BY_SID;
      else if (key_set(32'd0)) e.kind = ROUTE_DEFAULT_KEY;
      else e.kind = ROUTE_KERNEL_HASH;
      route_expect_q.push_back(e);
      pk_count   = '0;
      pk_udp_len = '0;
    end
  endtask

  // Mostly no gap, some short ones, a few long ones, and calm runs with none.
  function automatic int draw_gap(inout int calm_run);
    int r;
    if (calm_run > 0) begin
      calm_run--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 5) begin
      calm_run = $urandom_range(10, 40);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: feeds byte_q onto the in_ channel. in_valid gets one NBA per edge,
  // the payload only changes when a new request is loaded.
  // ---------------------------------------------------------------------------
  byte_req_t drv_req;
  bit        drv_busy = 1'b0;
  int        drv_gap  = 0;
  int        drv_calm = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      drv_busy = 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_route(drv_req);
        drv_busy = 1'b0;
        drv_gap  = draw_gap(drv_calm);
      end
      if (!drv_busy) begin
        if (drv_gap > 0) begin
          drv_gap--;
        end else if (byte_q.size() != 0) begin
          drv_req          = byte_q.pop_front();
          drv_busy         = 1'b1;
          in_data_byte     <= drv_req.data;
          in_start_byte    <= drv_req.first;
          in_last_byte     <= drv_req.last;
          in_packet_length <= drv_req.plen;
        end
      end
      in_valid <= drv_busy;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each accepted route against the oldest expectation and
  // draws the next out_stall.
  // ---------------------------------------------------------------------------
  int stall_left = 0;
  int mon_calm   = 0;

  always @(posedge clk) begin : mon
    route_expect_t e;
    int            g;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (route_expect_q.size() == 0) begin
          report_mismatch($sformatf("unexpected route kind=%0d sid=%h",
                                    out_route_kind, out_srv_id));
        end else begin
          e = route_expect_q.pop_front();
          if (out_route_kind !== e.kind)
            report_mismatch($sformatf("route_kind %0d, want %0d", out_route_kind, e.kind));
          if (out_srv_id !== e.sid)
            report_mismatch($sformatf("srv_id %h, want %h", out_srv_id, e.sid));
          if (out_id_extracted !== e.extracted)
            report_mismatch($sformatf("id_extracted %b, want %b",
                                      out_id_extracted, e.extracted));
          if (out_header_skipped !== e.skipped)
            report_mismatch($sformatf("header_skipped %b, want %b",
                                      out_header_skipped, e.skipped));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        g          = draw_gap(mon_calm);
        stall_left = (g > 0) ? g - 1 : 0;
        out_stall  <= (g > 0);
      end
    end
  end

  // Hard stop if the DUT hangs or drops a route
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL quic_cid_socket_router");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Block until all requests are in and all routes are out, then let the
  // pipeline drain bytes that produce no route.
  task automatic wait_idle();
    while (byte_q.size() != 0 || drv_busy || route_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [63:0] val);
    @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_wdata    <= val;
    case (idx)
      CFG_REGISTERED_MASK:  reg_mask      = val;
      CFG_EXPECTED_CID_LEN: reg_exp_cid   = val[7:0];
      CFG_MIN_LONG_LEN:     reg_min_long  = val[7:0];
      CFG_MIN_SHORT_LEN:    reg_min_short = val[7:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_write_en <= 1'b0;
  endtask

  // Turn pkt_bytes into requests. noisy drops extra first/last marks mid-packet.
  task automatic queue_packet_bytes(input logic [15:0] plen_field, input bit open,
                                    input bit close, input bit noisy);
    byte_req_t req;
    int        sz;
    sz = pkt_bytes.size();
    for (int i = 0; i < sz; i++) begin
      req.data  = pkt_bytes[i];
      req.first = (i == 0) ? open : (noisy && $urandom_range(0, 7) == 0);
      req.last  = (i == sz - 1) ? close : (noisy && $urandom_range(0, 9) == 0);
      req.plen  = (i == 0) ? plen_field : 16'($urandom);
      byte_q.push_back(req);
    end
    phase_items += sz;
  endtask

  // A packet that mostly parses: optional UDP header, short or long form,
  // length around the current minimum, sometimes truncated or mismatched.
  task automatic gen_wellformed();
    bit          use_udp, long_h;
    logic [31:0] sid;
    logic [15:0] plen_field;
    int unsigned hdr, need, plen, total, cid;
    octet_t      payload[$];
    use_udp = ($urandom_range(0, 2) == 0);
    long_h  = ($urandom_range(0, 1) == 1);
    case ($urandom_range(0, 3))
      0:       sid = $urandom_range(0, 63);
      1:       sid = $urandom_range(0, 2);
      2:       sid = $urandom;
      default: begin
        case ($urandom_range(0, 2))
          0:       sid = 32'd63;
          1:       sid = 32'd64;
          default: sid = 32'hFFFF_FFFF;
        endcase
      end
    endcase
    hdr  = long_h ? 10 : 5;
    need = long_h ? reg_min_long : reg_min_short;
    if (need < hdr) need = hdr;
    case ($urandom_range(0, 5))
      0:       plen = need - 1;                  // one short of the minimum
      1:       plen = $urandom_range(1, hdr);    // header bytes may be missing
      default: plen = need + $urandom_range(0, 3);
    endcase
    for (int i = 0; i < plen; i++) payload.push_back(8'($urandom_range(0, 255)));
    payload[0] = long_h ? (payload[0] | 8'h80) : (payload[0] & 8'h7F);
    if (long_h && plen > 5 && $urandom_range(0, 7) != 0) payload[5] = reg_exp_cid;
    cid = long_h ? 6 : 1;
    for (int j = 0; j < 4; j++)
      if (cid + j < plen) payload[cid + j] = sid[8*(3-j) +: 8];

    total = plen + (use_udp ? 8 : 0);
    pkt_bytes.delete();
    if (use_udp) begin
      for (int i = 0; i < 8; i++) pkt_bytes.push_back(8'($urandom_range(0, 255)));
      pkt_bytes[4] = total[15:8];
      pkt_bytes[5] = total[7:0];
      if ($urandom_range(0, 7) == 0) pkt_bytes[5] = pkt_bytes[5] ^ 8'h01;  // near miss
      plen_field = total[15:0];
    end else begin
      plen_field = ($urandom_range(0, 3) == 0) ? total[15:0] : 16'($urandom);
    end
    foreach (payload[i]) pkt_bytes.push_back(payload[i]);
    queue_packet_bytes(plen_field, 1'b1, 1'b1, 1'b0);
  endtask

  // Junk: stray starts, restarts, packets left open.
  task automatic gen_noise();
    int n;
    n = $urandom_range(1, 12);
    pkt_bytes.delete();
    for (int i = 0; i < n; i++) pkt_bytes.push_back(8'($urandom_range(0, 255)));
    queue_packet_bytes(16'($urandom), $urandom_range(0, 3) != 0,
                       $urandom_range(0, 3) != 0, 1'b1);
  endtask

  task automatic run_traffic();
    int pkts;
    pkts        = 0;
    phase_items = 0;
    while (phase_items < 32 || pkts < 3) begin
      if ($urandom_range(0, 9) < 7) gen_wellformed();
      else gen_noise();
      pkts++;
    end
    // sender holds off here until every route is back
    wait_idle();
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [63:0] m;
    logic [7:0]  e, l, s;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Traffic under reset register values
    run_traffic();

    // Directed: keys 0, 5 and 63 registered, small minimums
    write_reg(CFG_REGISTERED_MASK, 64'h8000_0000_0000_0021);
    write_reg(CFG_EXPECTED_CID_LEN, 64'd8);
    write_reg(CFG_MIN_LONG_LEN, 64'd10);
    write_reg(CFG_MIN_SHORT_LEN, 64'd5);

    // one-byte packet, first and last together
    pkt_bytes.delete();
    pkt_bytes.push_back(8'hFF);
    queue_packet_bytes(16'hFFFF, 1'b1, 1'b1, 1'b0);
    // stray byte with no first mark, keeps the held length
    pkt_bytes.delete();
    pkt_bytes.push_back(8'h00);
    queue_packet_bytes(16'h0000, 1'b0, 1'b1, 1'b0);
    // minimal short header, server id 5
    pkt_bytes.delete();
    for (int i = 0; i < 5; i++) pkt_bytes.push_back((i == 4) ? 8'h05 : 8'h00);
    queue_packet_bytes(16'h0000, 1'b1, 1'b1, 1'b0);
    // UDP header detected but nothing after it
    pkt_bytes.delete();
    for (int i = 0; i < 8; i++) pkt_bytes.push_back((i == 5) ? 8'h08 : 8'h00);
    queue_packet_bytes(16'd8, 1'b1, 1'b1, 1'b0);
    // minimal long header, DCID length 8, server id 63
    pkt_bytes.delete();
    pkt_bytes.push_back(8'hFF);
    for (int i = 1; i < 5; i++) pkt_bytes.push_back(8'($urandom_range(0, 255)));
    pkt_bytes.push_back(8'h08);
    for (int i = 6; i < 10; i++) pkt_bytes.push_back((i == 9) ? 8'h3F : 8'h00);
    queue_packet_bytes(16'($urandom), 1'b1, 1'b1, 1'b0);
    wait_idle();

    // Random phases, extremes first
    for (int p = 0; p < 9; p++) begin
      case (p)
        0: begin m = '1; e = 8'd0; l = 8'd1; s = 8'd1; end
        1: begin m = '0; e = 8'd255; l = 8'd255; s = 8'd255; end
        2: begin m = 64'd1; e = RST_EXPECTED_CID_LEN; l = RST_MIN_LONG_LEN;
                 s = RST_MIN_SHORT_LEN; end
        default: begin
          m = {$urandom, $urandom};
          e = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(4, 20));
          l = 8'($urandom_range(1, 24));
          s = 8'($urandom_range(1, 16));
        end
      endcase
      write_reg(CFG_REGISTERED_MASK, m);
      write_reg(CFG_EXPECTED_CID_LEN, {56'd0, e});
      write_reg(CFG_MIN_LONG_LEN, {56'd0, l});
      write_reg(CFG_MIN_SHORT_LEN, {56'd0, s});
      run_traffic();
    end

    wait_idle();
    if (mismatch_count == 0) begin
      $display("PASS quic_cid_socket_router");
    end else begin
      $display("FAIL quic_cid_socket_router");
    end
    $finish;
  end

endmodule
